// File: design/fpvi_pkg.sv
// ----------------------------------------------------------------------------
// fpvi_pkg
// Shared types and constants for the fixed-priority vectored irq unit.
// ----------------------------------------------------------------------------
package fpvi_pkg;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 3;
  localparam int VEC_W   = 8;
  localparam int COUNT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_RAISE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ACK    = 2'd2,
    OP_POLL   = 2'd3
  } op_t;

  // command broadcast to every cell for one accepted transaction
  typedef struct packed {
    logic raise;
    logic cancel;
    logic ack;
  } cell_cmd_t;

  // data handed from one cell to the next lower-priority cell
  typedef struct packed {
    logic             any_pend;
    logic             hit;
    logic [VEC_W-1:0] vec;
  } cell_link_t;

endpackage

// File: design/fpvi_if.sv
// ----------------------------------------------------------------------------
// fpvi_in_if / fpvi_out_if
// Valid/ready channels carrying irq requests and their results.
// ----------------------------------------------------------------------------
interface fpvi_in_if;
  logic                           valid;
  logic                           ready;
  fpvi_pkg::op_t                  op;
  logic [fpvi_pkg::SLOT_W-1:0]    priority_req;
  logic [fpvi_pkg::VEC_W-1:0]     vector_in;

  modport source (output valid, op, priority_req, vector_in, input ready);
  modport sink   (input valid, op, priority_req, vector_in, output ready);
endinterface

interface fpvi_out_if;
  logic                           valid;
  logic                           ready;
  logic [fpvi_pkg::VEC_W-1:0]     vector_out;
  logic                           irq_line;
  logic [fpvi_pkg::COUNT_W-1:0]   pending_count;
  logic                           ack_empty;

  modport source (output valid, vector_out, irq_line, pending_count, ack_empty,
                  input ready);
  modport sink   (input valid, vector_out, irq_line, pending_count, ack_empty,
                  output ready);
endinterface

// File: design/fpvi_cell.sv
// ----------------------------------------------------------------------------
// fpvi_cell
// One priority slot: request flag, vector byte and its link in the chain.
// ----------------------------------------------------------------------------
module fpvi_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  fpvi_pkg::cell_cmd_t          cmd,
  input  logic                         sel,
  input  logic [fpvi_pkg::VEC_W-1:0]   vector_in,
  input  fpvi_pkg::cell_link_t         link_in,
  output fpvi_pkg::cell_link_t         link_out
);
  import fpvi_pkg::*;

  logic             flag;
  logic [VEC_W-1:0] vbyte;
  logic             grant;

  // a pending slot wins only if nothing above it is pending
  assign grant = flag && !link_in.any_pend;

  assign link_out.any_pend = link_in.any_pend | flag;
  assign link_out.hit      = link_in.hit | (sel & flag);
  assign link_out.vec      = link_in.vec | (grant ? vbyte : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else begin
      priority if (cmd.raise && sel) begin
        flag <= 1'b1;
      end else if ((cmd.cancel && sel) || (cmd.ack && grant)) begin
        flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.raise && sel) begin
      vbyte <= vector_in;
    end
  end

endmodule

// File: design/fixed_priority_vectored_irq_unit.sv
// ----------------------------------------------------------------------------
// fixed_priority_vectored_irq_unit
// Fixed-priority vectored interrupt collector built as a chain of slot cells.
// ----------------------------------------------------------------------------
// usage:
//   req channel takes one transaction: op (raise, cancel, acknowledge, poll),
//   priority_req (slot for raise and cancel, 0 highest) and vector_in (byte
//   stored by raise). every transaction yields one transaction on rsp:
//   vector_out, irq_line, pending_count and ack_empty after that operation.
//   the result is registered on the edge that takes the request. throughput
//   is one transaction per cycle unless rsp stalls; the priority search is
//   a combinational ripple through the SLOT_COUNT cells, one cell per slot,
//   so that chain length sets the clock period.
//   req.ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and blocks new requests.
//   reset clears all request flags, the pending count, the line and the
//   output register; vector bytes are only read after a raise wrote them.
// ----------------------------------------------------------------------------
module fixed_priority_vectored_irq_unit #(
  parameter int SLOT_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst,
  fpvi_in_if.sink      req,
  fpvi_out_if.source   rsp
);
  import fpvi_pkg::*;

  logic               accept;
  logic               slot_ok;
  cell_cmd_t          cmd;
  logic [SLOT_COUNT-1:0] sel;
  cell_link_t         link [SLOT_COUNT+1];

  logic [COUNT_W-1:0] pending_total;
  logic [COUNT_W-1:0] pending_total_next;
  logic               line_level;
  logic               line_level_next;
  logic [VEC_W-1:0]   vec_next;
  logic               empty_next;

  logic               out_valid;
  logic [VEC_W-1:0]   vector_out;
  logic               ack_empty;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign slot_ok   = int'(req.priority_req) < SLOT_COUNT;

  assign cmd.raise  = accept && (req.op == OP_RAISE);
  assign cmd.cancel = accept && (req.op == OP_CANCEL);
  assign cmd.ack    = accept && (req.op == OP_ACK);

  assign link[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    assign sel[i] = int'(req.priority_req) == i;

    fpvi_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .sel       (sel[i]),
      .vector_in (req.vector_in),
      .link_in   (link[i]),
      .link_out  (link[i+1])
    );
  end

  always_comb begin
    pending_total_next = pending_total;
    line_level_next    = line_level;
    vec_next           = '0;
    empty_next         = 1'b0;
    unique case (req.op)
      OP_RAISE: begin
        if (slot_ok && !link[SLOT_COUNT].hit) begin
          pending_total_next = pending_total + COUNT_W'(1);
        end
      end
      OP_CANCEL: begin
        if (link[SLOT_COUNT].hit && pending_total != '0) begin
          pending_total_next = pending_total - COUNT_W'(1);
        end
      end
      OP_ACK: begin
        if (link[SLOT_COUNT].any_pend) begin
          vec_next = link[SLOT_COUNT].vec;
          if (pending_total != '0) begin
            pending_total_next = pending_total - COUNT_W'(1);
          end
        end else begin
          empty_next = 1'b1;
        end
        if (pending_total_next == '0) begin
          line_level_next = 1'b0;
        end
      end
      OP_POLL: begin
        if (pending_total != '0) begin
          line_level_next = 1'b1;
        end
      end
      default: begin
        pending_total_next = pending_total;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_total <= '0;
      line_level    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        pending_total <= pending_total_next;
        line_level    <= line_level_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vector_out <= vec_next;
      ack_empty  <= empty_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.vector_out    = vector_out;
  assign rsp.irq_line      = line_level;
  assign rsp.pending_count = pending_total;
  assign rsp.ack_empty     = ack_empty;

endmodule

// File: design/fpvi_chk.sv
// ----------------------------------------------------------------------------
// fpvi_chk
// Port-level checks for the fixed-priority vectored irq unit.
// ----------------------------------------------------------------------------
module fpvi_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [fpvi_pkg::VEC_W-1:0]      vector_out,
  input logic                            irq_line,
  input logic [fpvi_pkg::COUNT_W-1:0]    pending_count,
  input logic                            ack_empty
);
  import fpvi_pkg::*;

  // reset empties the result register
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // an empty acknowledge means no request was held and the line is down
  a_empty_ack: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ack_empty |->
      vector_out == '0 && !irq_line && pending_count == '0)
    else $error("empty acknowledge with pending state");

  // at most eight slots are reachable through the slot field
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending_count <= COUNT_W'(8))
    else $error("pending count out of range");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(vector_out) && $stable(irq_line) && $stable(pending_count)
      && $stable(ack_empty))
    else $error("result changed while stalled");

endmodule

bind fixed_priority_vectored_irq_unit fpvi_chk u_fpvi_chk (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .vector_out    (rsp.vector_out),
  .irq_line      (rsp.irq_line),
  .pending_count (rsp.pending_count),
  .ack_empty     (rsp.ack_empty)
);
